// ===== design/pcbe_pkg.sv =====
//------------------------------------------------------------------------------
// pcbe_pkg
// Shared types, constants and arithmetic helpers for the cubic Bezier
// chain evaluator.
//------------------------------------------------------------------------------
`default_nettype none

package pcbe_pkg;

	localparam int MAX_ARCS    = 64;
	localparam int FRAC_BITS   = 16;
	localparam int NODE_COUNT  = 3 * MAX_ARCS + 1;
	localparam int ARC_W       = $clog2(MAX_ARCS);
	localparam int ROW_W       = $clog2(MAX_ARCS + 1);
	localparam int WIDE_W      = 44;
	localparam int PROD_W      = 62;
	localparam int TAN_W       = 40;

	localparam logic REG_ARC_COUNT  = 1'b0;
	localparam logic REG_END_OFFSET = 1'b1;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	localparam logic [FRAC_BITS:0] ONE_PARAM = 17'h10000;

	typedef logic signed [31:0]         coord_t;
	typedef logic signed [WIDE_W-1:0]   wide_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [TAN_W-1:0]    deriv_t;
	typedef logic signed [FRAC_BITS+1:0] uparm_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} node_t;

	typedef struct packed {
		logic mid;
		logic last;
	} ctl_t;

	// round to nearest, ties up, then drop the fraction
	function automatic wide_t round_shift(input prod_t p);
		prod_t s;
		s = p + (prod_t'(1) <<< (FRAC_BITS - 1));
		return wide_t'(s >>> FRAC_BITS);
	endfunction

	function automatic coord_t sat_pos(input wide_t v);
		if (v > wide_t'(32'sh7fffffff))
			return 32'sh7fffffff;
		else if (v < -wide_t'(33'sh080000000))
			return 32'sh80000000;
		else
			return coord_t'(v);
	endfunction

	function automatic deriv_t sat_der(input wide_t v);
		if (v > wide_t'(40'sh7fffffffff))
			return 40'sh7fffffffff;
		else if (v < -wide_t'(41'sh08000000000))
			return 40'sh8000000000;
		else
			return deriv_t'(v);
	endfunction

endpackage

`default_nettype wire

// ===== design/pcbe_node_store.sv =====
//------------------------------------------------------------------------------
// pcbe_node_store
// Control node memories, banked by node index mod 3 so one arc's four
// nodes come out in a single registered read.
//------------------------------------------------------------------------------
`default_nettype none

module pcbe_node_store (
	input  wire logic                    clk,
	input  wire logic                    wr_en,
	input  wire logic [7:0]              wr_index,
	input  wire pcbe_pkg::node_t         wr_node,
	input  wire logic                    rd_en,
	input  wire logic [pcbe_pkg::ARC_W-1:0] rd_arc,
	output pcbe_pkg::node_t              p0,
	output pcbe_pkg::node_t              p1,
	output pcbe_pkg::node_t              p2,
	output pcbe_pkg::node_t              p3
);
	import pcbe_pkg::*;

	node_t joint_mem [MAX_ARCS+1];
	node_t mid1_mem  [MAX_ARCS];
	node_t mid2_mem  [MAX_ARCS];

	logic [15:0]      div_prod;
	logic [ROW_W-1:0] row;
	logic [1:0]       bank;
	logic [7:0]       row_x3;
	logic [ROW_W-1:0] rd_next;

	// n / 3 by reciprocal, exact for 8-bit n
	assign div_prod = wr_index * 8'd171;
	assign row      = div_prod[9 +: ROW_W];
	assign row_x3   = 8'(row) * 8'd3;
	assign bank     = 2'(wr_index - row_x3);
	assign rd_next  = ROW_W'(rd_arc) + ROW_W'(1);

	always_ff @(posedge clk) begin
		if (wr_en && (wr_index < 8'(NODE_COUNT))) begin
			case (bank)
				2'd0:    joint_mem[row] <= wr_node;
				2'd1:    mid1_mem[row[ARC_W-1:0]] <= wr_node;
				2'd2:    mid2_mem[row[ARC_W-1:0]] <= wr_node;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			p0 <= joint_mem[ROW_W'(rd_arc)];
			p3 <= joint_mem[rd_next];
			p1 <= mid1_mem[rd_arc];
			p2 <= mid2_mem[rd_arc];
		end
	end

endmodule

`default_nettype wire

// ===== design/pcbe_coord_unit.sv =====
//------------------------------------------------------------------------------
// pcbe_coord_unit
// One coordinate of the cubic evaluation: point, first and second
// derivative, seven register stages from node data to saturated result.
//------------------------------------------------------------------------------
`default_nettype none

module pcbe_coord_unit (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire pcbe_pkg::coord_t  p0,
	input  wire pcbe_pkg::coord_t  p1,
	input  wire pcbe_pkg::coord_t  p2,
	input  wire pcbe_pkg::coord_t  p3,
	input  wire pcbe_pkg::uparm_t  u,
	input  wire pcbe_pkg::ctl_t    ctl,
	output pcbe_pkg::coord_t       pos,
	output pcbe_pkg::deriv_t       tan,
	output pcbe_pkg::deriv_t       acc
);
	import pcbe_pkg::*;

	wide_t  w0, w1, w2, w3, a, b, c;
	wide_t  a_s3, a3_s3, a6_s3, b3_s3, b6_s3, c3_s3, pend_s3;
	uparm_t u_s3, u_s4, u_s5, u_s6, u_s7;
	ctl_t   ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8;
	prod_t  m1_s4, m3_s4, m6_s4;
	wide_t  b3_s4, b6_s4, c3_s4, pend_s4;
	wide_t  h1_s5, ht_s5, acc_s5, c3_s5, pend_s5;
	prod_t  q1_s6, qt_s6;
	wide_t  acc_s6, c3_s6, pend_s6;
	wide_t  h2_s7, tan_s7, acc_s7, pend_s7;
	prod_t  q2_s8;
	wide_t  tan_s8, acc_s8, pend_s8;
	wide_t  pos_w;

	assign w0 = wide_t'(p0);
	assign w1 = wide_t'(p1);
	assign w2 = wide_t'(p2);
	assign w3 = wide_t'(p3);
	assign a  = w3 + 3 * (w1 - w2) - w0;
	assign b  = w0 - (w1 <<< 1) + w2;
	assign c  = w1 - w0;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3    <= a;
			a3_s3   <= 3 * a;
			a6_s3   <= 6 * a;
			b3_s3   <= 3 * b;
			b6_s3   <= 6 * b;
			c3_s3   <= 3 * c;
			pend_s3 <= ctl.last ? w3 : w0;
			u_s3    <= u;
			ctl_s3  <= ctl;

			m1_s4   <= prod_t'(a_s3) * prod_t'(u_s3);
			m3_s4   <= prod_t'(a3_s3) * prod_t'(u_s3);
			m6_s4   <= prod_t'(a6_s3) * prod_t'(u_s3);
			b3_s4   <= b3_s3;
			b6_s4   <= b6_s3;
			c3_s4   <= c3_s3;
			pend_s4 <= pend_s3;
			u_s4    <= u_s3;
			ctl_s4  <= ctl_s3;

			h1_s5   <= round_shift(m1_s4) + b3_s4;
			ht_s5   <= round_shift(m3_s4) + b6_s4;
			acc_s5  <= round_shift(m6_s4) + b6_s4;
			c3_s5   <= c3_s4;
			pend_s5 <= pend_s4;
			u_s5    <= u_s4;
			ctl_s5  <= ctl_s4;

			q1_s6   <= prod_t'(h1_s5) * prod_t'(u_s5);
			qt_s6   <= prod_t'(ht_s5) * prod_t'(u_s5);
			acc_s6  <= acc_s5;
			c3_s6   <= c3_s5;
			pend_s6 <= pend_s5;
			u_s6    <= u_s5;
			ctl_s6  <= ctl_s5;

			h2_s7   <= round_shift(q1_s6) + c3_s6;
			tan_s7  <= round_shift(qt_s6) + c3_s6;
			acc_s7  <= acc_s6;
			pend_s7 <= pend_s6;
			u_s7    <= u_s6;
			ctl_s7  <= ctl_s6;

			q2_s8   <= prod_t'(h2_s7) * prod_t'(u_s7);
			tan_s8  <= tan_s7;
			acc_s8  <= acc_s7;
			pend_s8 <= pend_s7;
			ctl_s8  <= ctl_s7;

			pos <= sat_pos(pos_w);
			tan <= sat_der(tan_s8);
			acc <= sat_der(acc_s8);
		end
	end

	// curve ends return the end node itself
	assign pos_w = ctl_s8.mid ? (round_shift(q2_s8) + pend_s8) : pend_s8;

endmodule

`default_nettype wire

// ===== design/piecewise_cubic_bezier_eval_core.sv =====
//------------------------------------------------------------------------------
// piecewise_cubic_bezier_eval_core
// Composite cubic Bezier evaluator: node store plus point/derivative pipe.
//
// Requests enter on s_axis; tuser = 0 loads one control node (no result),
// tuser = 1 evaluates the curve at curve_param and yields one result on
// m_axis carrying point, first and second derivative per axis.
// Configuration (arc count, end offset) goes through cfg_wr_en/cfg_addr/
// cfg_wdata; the user must change it only while no evaluation is in
// flight, the block itself does not enforce this.
// Nine register stages lie between an accepted request and its result.
// Throughput: one request per cycle unless m_axis stalls; node loads and
// evaluations mix freely, a load takes effect for every later evaluation.
// The whole pipe advances together: when m_axis is stalled with a result
// waiting, s_axis_tready drops and every stage holds; with no result
// waiting the pipe runs and bubbles keep moving.
// Reset clears the valid bits and sets arc count 1, end offset 655; node
// memories hold nothing until loaded.
//------------------------------------------------------------------------------
`default_nettype none

module piecewise_cubic_bezier_eval_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_wr_en,
	input  wire logic          cfg_addr,
	input  wire logic [15:0]   cfg_wdata,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	// node_index, node_x, node_y, node_z, curve_param, zero pad
	input  wire logic [127:0]  s_axis_tdata,
	// req_type
	input  wire logic          s_axis_tuser,
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	// pos_x, pos_y, pos_z, tan_x, tan_y, tan_z, acc_x, acc_y, acc_z
	output logic [335:0]       m_axis_tdata
);
	import pcbe_pkg::*;

	logic [6:0]  arc_count_q;
	logic [15:0] end_offset_q;
	logic [6:0]  arcs;
	logic        en, accept;

	logic [7:0]          in_index;
	node_t               in_node;
	logic signed [17:0]  in_param;
	logic [FRAC_BITS:0]  t_cl;
	logic [22:0]         scaled;
	logic [ARC_W-1:0]    k_n;
	logic [FRAC_BITS:0]  u_n;
	logic                t_zero, t_one;

	logic [ARC_W-1:0]    k_s1;
	logic [FRAC_BITS:0]  u_s1, u_s2;
	ctl_t                ctl_s1, ctl_s2;
	logic [9:1]          v_s;

	node_t               p0, p1, p2, p3;
	coord_t              pos [3];
	deriv_t              tan [3];
	deriv_t              acc [3];

	assign in_index = s_axis_tdata[7:0];
	assign in_node  = '{x: s_axis_tdata[39:8], y: s_axis_tdata[71:40],
			z: s_axis_tdata[103:72]};
	assign in_param = s_axis_tdata[121:104];

	assign en            = !v_s[9] || m_axis_tready;
	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arc_count_q  <= 7'd1;
			end_offset_q <= 16'd655;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_ARC_COUNT:  arc_count_q  <= cfg_wdata[6:0];
				REG_END_OFFSET: end_offset_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		arcs = arc_count_q;
		if (arcs == 7'd0)
			arcs = 7'd1;
		else if (arcs > 7'(MAX_ARCS))
			arcs = 7'(MAX_ARCS);

		if (in_param < 0)
			t_cl = '0;
		else if (in_param > 18'sd65536)
			t_cl = ONE_PARAM;
		else
			t_cl = in_param[FRAC_BITS:0];

		t_zero = (t_cl == '0);
		t_one  = (t_cl == ONE_PARAM);
		scaled = t_cl[FRAC_BITS-1:0] * arcs;

		if (t_zero) begin
			k_n = '0;
			u_n = {1'b0, end_offset_q};
		end else if (t_one) begin
			k_n = ARC_W'(arcs - 7'd1);
			u_n = ONE_PARAM - {1'b0, end_offset_q};
		end else begin
			k_n = scaled[FRAC_BITS +: ARC_W];
			u_n = {1'b0, scaled[FRAC_BITS-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[8:1], accept && (s_axis_tuser == REQ_EVAL)};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s1   <= k_n;
			u_s1   <= u_n;
			ctl_s1 <= '{mid: !t_zero && !t_one, last: t_one};
			u_s2   <= u_s1;
			ctl_s2 <= ctl_s1;
		end
	end

	pcbe_node_store u_store (
		.clk      (clk),
		.wr_en    (accept && (s_axis_tuser == REQ_LOAD)),
		.wr_index (in_index),
		.wr_node  (in_node),
		.rd_en    (en),
		.rd_arc   (k_s1),
		.p0       (p0),
		.p1       (p1),
		.p2       (p2),
		.p3       (p3)
	);

	pcbe_coord_unit u_cx (
		.clk (clk), .en (en),
		.p0 (p0.x), .p1 (p1.x), .p2 (p2.x), .p3 (p3.x),
		.u ({1'b0, u_s2}), .ctl (ctl_s2),
		.pos (pos[0]), .tan (tan[0]), .acc (acc[0])
	);

	pcbe_coord_unit u_cy (
		.clk (clk), .en (en),
		.p0 (p0.y), .p1 (p1.y), .p2 (p2.y), .p3 (p3.y),
		.u ({1'b0, u_s2}), .ctl (ctl_s2),
		.pos (pos[1]), .tan (tan[1]), .acc (acc[1])
	);

	pcbe_coord_unit u_cz (
		.clk (clk), .en (en),
		.p0 (p0.z), .p1 (p1.z), .p2 (p2.z), .p3 (p3.z),
		.u ({1'b0, u_s2}), .ctl (ctl_s2),
		.pos (pos[2]), .tan (tan[2]), .acc (acc[2])
	);

	assign m_axis_tvalid = v_s[9];
	assign m_axis_tdata  = {acc[2], acc[1], acc[0], tan[2], tan[1], tan[0],
			pos[2], pos[1], pos[0]};

`ifndef SYNTH
	a_stall_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without an output stall");

	a_arc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[1] |-> ({1'b0, k_s1} < arcs))
		else $error("arc index beyond arc count");

	a_param_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[1] |-> (u_s1 <= ONE_PARAM))
		else $error("local parameter above one");
`endif

endmodule

`default_nettype wire
